>>> rtl/rcte_pkg.sv
`default_nettype none

package rcte_pkg;

  // field widths
  localparam int unsigned SampleW  = 16;
  localparam int unsigned TorqueW  = 17;
  localparam int unsigned RmsW     = 16;
  localparam int unsigned CfgW     = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned MulW     = 17;
  localparam int unsigned ProdW    = 2 * MulW;
  localparam int unsigned InDataW  = 32;
  localparam int unsigned OutDataW = 40;

  // frame length default
  localparam int unsigned PairsPerFrameDef = 64;

  // square root works on a 32-bit window, two bits per step
  localparam int unsigned SqrtSteps = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] RegNoiseThr  = 3'd0;
  localparam logic [CfgIdxW-1:0] RegFwdOffset = 3'd1;
  localparam logic [CfgIdxW-1:0] RegFwdGain   = 3'd2;
  localparam logic [CfgIdxW-1:0] RegRevOffset = 3'd3;
  localparam logic [CfgIdxW-1:0] RegRevGain   = 3'd4;

  // register reset values
  localparam logic [CfgW-1:0] NoiseThrRst  = 16'd200;
  localparam logic [CfgW-1:0] FwdOffsetRst = 16'd2675;
  localparam logic [CfgW-1:0] FwdGainRst   = 16'd197;
  localparam logic [CfgW-1:0] RevOffsetRst = 16'd2036;
  localparam logic [CfgW-1:0] RevGainRst   = 16'd305;

  // torque limits
  localparam logic [25:0] TorqueMaxMag = 26'd65535;
  localparam logic [25:0] TorqueMinMag = 26'd65536;

  // multiplier request
  typedef struct packed {
    logic signed [MulW-1:0] a;
    logic signed [MulW-1:0] b;
  } rcte_mul_req_t;

  // Q17.16 product to Q8.8: round half away from zero, optional negate, saturate
  function automatic logic signed [TorqueW-1:0] round_sat(
    input logic signed [ProdW-1:0] prod,
    input logic                    rev
  );
    logic [ProdW-1:0]   mag;
    logic [ProdW-1:0]   rnd;
    logic [25:0]        q;
    logic               neg;
    logic [TorqueW-1:0] res;
    mag = prod[ProdW-1] ? (~prod + 1'b1) : prod;
    rnd = mag + ProdW'(128);
    q   = rnd[33:8];
    neg = prod[ProdW-1] ^ rev;
    if (neg) begin
      if (q > TorqueMinMag) begin
        res = {1'b1, 16'd0};
      end else begin
        res = ~q[TorqueW-1:0] + 1'b1;
      end
    end else begin
      if (q > TorqueMaxMag) begin
        res = {1'b0, 16'hFFFF};
      end else begin
        res = q[TorqueW-1:0];
      end
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/rms_current_torque_estimator_top.sv
`default_nettype none

// rms current torque estimator: takes one pair of current-sense samples per
// transaction (even = forward channel, odd = reverse channel), sums the
// squares of both channels over a frame of up to PAIRS_PER_FRAME pairs and,
// on the pair marked by tlast, returns one result transaction: the integer
// square root of the selected channel's mean square (tuser = 1 selects the
// reverse channel) and the torque (root - offset) * gain in signed Q8.8,
// negated for reverse, saturated, and zero when the root is at or below the
// noise threshold. pairs beyond PAIRS_PER_FRAME are dropped but the frame
// still closes on tlast. the two squares of every pair share one multiplier;
// the closing pair then runs a bit-serial restoring divide of SUM_W steps and
// a 16-step square root, both on one shared subtractor. s_axis_tready stays
// low while a pair is in flight; a finished result waits in the output
// register while the next pair is taken, and a closing pair holds in its last
// step for as long as the previous result is still waiting there.
module rms_current_torque_estimator_top #(
  parameter int unsigned PAIRS_PER_FRAME = rcte_pkg::PairsPerFrameDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  // sample pair stream
  input  wire logic                            s_axis_tvalid_i,
  output logic                                 s_axis_tready_o,
  // [15:0] sample_even, [31:16] sample_odd
  input  wire logic [rcte_pkg::InDataW-1:0]    s_axis_tdata_i,
  // [0] reverse_dir
  input  wire logic [0:0]                      s_axis_tuser_i,
  // frame_last
  input  wire logic                            s_axis_tlast_i,
  // result stream
  output logic                                 m_axis_tvalid_o,
  input  wire logic                            m_axis_tready_i,
  // [16:0] torque_q8, [32:17] rms_level, [39:33] zero
  output logic [rcte_pkg::OutDataW-1:0]        m_axis_tdata_o,
  // configuration writes
  input  wire logic                            cfg_we_i,
  input  wire logic [rcte_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [rcte_pkg::CfgW-1:0]       cfg_data_i
);
  import rcte_pkg::*;

  localparam int unsigned CNT_W  = $clog2(PAIRS_PER_FRAME + 1);
  localparam int unsigned SUM_W  = 31 + CNT_W;
  localparam int unsigned ITER_W = $clog2(SUM_W);
  localparam int unsigned OP_W   = (CNT_W + 1 > 19) ? CNT_W + 1 : 19;

  // sequencer codes
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_SQE   = 4'd1;
  localparam logic [3:0] ST_SQO   = 4'd2;
  localparam logic [3:0] ST_ACC   = 4'd3;
  localparam logic [3:0] ST_DSET  = 4'd4;
  localparam logic [3:0] ST_DIV   = 4'd5;
  localparam logic [3:0] ST_SQRT  = 4'd6;
  localparam logic [3:0] ST_SCALE = 4'd7;
  localparam logic [3:0] ST_FIN   = 4'd8;

  // configuration registers
  logic [CfgW-1:0] noise_thr_q, fwd_offset_q, fwd_gain_q, rev_offset_q, rev_gain_q;

  // control
  logic [3:0]        state_q, state_d;
  logic [CNT_W-1:0]  pair_cnt_q, pair_cnt_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  // payload
  logic signed [SampleW-1:0] even_q, even_d, odd_q, odd_d;
  logic                      rev_q, rev_d, last_q, last_d;
  logic [SUM_W-1:0]          sum_even_q, sum_even_d, sum_odd_q, sum_odd_d;
  logic [SUM_W-1:0]          num_q, num_d;
  logic [CNT_W-1:0]          rem_q, rem_d;
  logic [16:0]               sq_rem_q, sq_rem_d;
  logic [RmsW-1:0]           root_q, root_d;
  logic [TorqueW-1:0]        torque_q, torque_d;
  logic [RmsW-1:0]           rms_q, rms_d;

  // shared unit
  logic [OP_W-1:0]          sub_a, sub_b, sub_diff;
  logic                     sub_ge;
  rcte_mul_req_t            mul_req;
  logic signed [ProdW-1:0]  prod;

  logic             accum_en;
  logic [SUM_W-1:0] square_ext;
  logic [CNT_W:0]   div_sh;
  logic [18:0]      sqrt_sh;
  logic [17:0]      sqrt_trial;
  logic             in_acc;
  logic             out_acc;

  assign in_acc   = s_axis_tvalid_i & s_axis_tready_o;
  assign out_acc  = out_valid_q & m_axis_tready_i;
  assign accum_en = (pair_cnt_q < CNT_W'(PAIRS_PER_FRAME));

  // squares are never negative and stay at or below 2^30
  assign square_ext = {{(SUM_W-31){1'b0}}, prod[30:0]};

  assign div_sh     = {rem_q, num_q[SUM_W-1]};
  assign sqrt_sh    = {sq_rem_q, num_q[31:30]};
  assign sqrt_trial = {root_q, 2'b01};

  rcte_alu #(
    .OpW (OP_W)
  ) u_alu (
    .clk_i      (clk_i),
    .sub_a_i    (sub_a),
    .sub_b_i    (sub_b),
    .sub_diff_o (sub_diff),
    .sub_ge_o   (sub_ge),
    .mul_req_i  (mul_req),
    .prod_o     (prod)
  );

  // operand selection for the shared unit
  always_comb begin
    sub_a     = OP_W'(div_sh);
    sub_b     = OP_W'(pair_cnt_q);
    mul_req.a = MulW'(even_q);
    mul_req.b = MulW'(even_q);
    if (state_q == ST_SQRT) begin
      sub_a = OP_W'(sqrt_sh);
      sub_b = OP_W'(sqrt_trial);
    end
    if (state_q == ST_SQO) begin
      mul_req.a = MulW'(odd_q);
      mul_req.b = MulW'(odd_q);
    end else if (state_q == ST_SCALE || state_q == ST_FIN) begin
      // root minus offset, times an unsigned gain; kept through the output wait
      mul_req.a = $signed({1'b0, root_q}) -
                  $signed({1'b0, (rev_q ? rev_offset_q : fwd_offset_q)});
      mul_req.b = $signed({1'b0, (rev_q ? rev_gain_q : fwd_gain_q)});
    end
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    pair_cnt_d  = pair_cnt_q;
    iter_d      = iter_q;
    out_valid_d = out_valid_q & ~out_acc;
    even_d      = even_q;
    odd_d       = odd_q;
    rev_d       = rev_q;
    last_d      = last_q;
    sum_even_d  = sum_even_q;
    sum_odd_d   = sum_odd_q;
    num_d       = num_q;
    rem_d       = rem_q;
    sq_rem_d    = sq_rem_q;
    root_d      = root_q;
    torque_d    = torque_q;
    rms_d       = rms_q;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          even_d  = s_axis_tdata_i[15:0];
          odd_d   = s_axis_tdata_i[31:16];
          rev_d   = s_axis_tuser_i[0];
          last_d  = s_axis_tlast_i;
          state_d = ST_SQE;
        end
      end
      ST_SQE: begin
        state_d = ST_SQO;
      end
      ST_SQO: begin
        if (accum_en) begin
          sum_even_d = sum_even_q + square_ext;
        end
        state_d = ST_ACC;
      end
      ST_ACC: begin
        if (accum_en) begin
          sum_odd_d  = sum_odd_q + square_ext;
          pair_cnt_d = pair_cnt_q + 1'b1;
        end
        state_d = last_q ? ST_DSET : ST_IDLE;
      end
      ST_DSET: begin
        // latch the selected sum and clear both frame sums
        num_d      = rev_q ? sum_odd_q : sum_even_q;
        rem_d      = '0;
        sum_even_d = '0;
        sum_odd_d  = '0;
        iter_d     = ITER_W'(SUM_W - 1);
        state_d    = ST_DIV;
      end
      ST_DIV: begin
        // restoring divide by the pair count, one quotient bit a cycle
        rem_d = sub_ge ? sub_diff[CNT_W-1:0] : div_sh[CNT_W-1:0];
        num_d = {num_q[SUM_W-2:0], sub_ge};
        if (iter_q == '0) begin
          pair_cnt_d = '0;
          sq_rem_d   = '0;
          root_d     = '0;
          iter_d     = ITER_W'(SqrtSteps - 1);
          state_d    = ST_SQRT;
        end else begin
          iter_d = iter_q - 1'b1;
        end
      end
      ST_SQRT: begin
        // digit-by-digit root, two radicand bits a cycle
        sq_rem_d = sub_ge ? sub_diff[16:0] : sqrt_sh[16:0];
        root_d   = {root_q[RmsW-2:0], sub_ge};
        num_d    = {num_q[SUM_W-3:0], 2'b00};
        if (iter_q == '0) begin
          state_d = ST_SCALE;
        end else begin
          iter_d = iter_q - 1'b1;
        end
      end
      ST_SCALE: begin
        state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || m_axis_tready_i) begin
          out_valid_d = 1'b1;
          rms_d       = root_q;
          torque_d    = (root_q > noise_thr_q) ? round_sat(prod, rev_q) : '0;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pair_cnt_q  <= '0;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
      sum_even_q  <= '0;
      sum_odd_q   <= '0;
    end else begin
      state_q     <= state_d;
      pair_cnt_q  <= pair_cnt_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
      sum_even_q  <= sum_even_d;
      sum_odd_q   <= sum_odd_d;
    end
  end

  always_ff @(posedge clk_i) begin
    even_q   <= even_d;
    odd_q    <= odd_d;
    rev_q    <= rev_d;
    last_q   <= last_d;
    num_q    <= num_d;
    rem_q    <= rem_d;
    sq_rem_q <= sq_rem_d;
    root_q   <= root_d;
    torque_q <= torque_d;
    rms_q    <= rms_d;
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      noise_thr_q  <= NoiseThrRst;
      fwd_offset_q <= FwdOffsetRst;
      fwd_gain_q   <= FwdGainRst;
      rev_offset_q <= RevOffsetRst;
      rev_gain_q   <= RevGainRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        RegNoiseThr:  noise_thr_q  <= cfg_data_i;
        RegFwdOffset: fwd_offset_q <= cfg_data_i;
        RegFwdGain:   fwd_gain_q   <= cfg_data_i;
        RegRevOffset: rev_offset_q <= cfg_data_i;
        RegRevGain:   rev_gain_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {7'd0, rms_q, torque_q};

endmodule

`default_nettype wire

>>> rtl/rcte_alu.sv
`default_nettype none

// shared compare/subtract unit plus registered 17x17 signed multiplier
module rcte_alu #(
  parameter int unsigned OpW = 19
) (
  input  wire logic                                 clk_i,
  input  wire logic [OpW-1:0]                       sub_a_i,
  input  wire logic [OpW-1:0]                       sub_b_i,
  output logic      [OpW-1:0]                       sub_diff_o,
  output logic                                      sub_ge_o,
  input  wire rcte_pkg::rcte_mul_req_t              mul_req_i,
  output logic signed [rcte_pkg::ProdW-1:0]         prod_o
);
  import rcte_pkg::*;

  logic [OpW:0]             sub_full;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [ProdW-1:0]  prod_d;

  assign sub_full   = {1'b0, sub_a_i} - {1'b0, sub_b_i};
  assign sub_diff_o = sub_full[OpW-1:0];
  assign sub_ge_o   = ~sub_full[OpW];

  assign prod_d = ProdW'(mul_req_i.a) * ProdW'(mul_req_i.b);

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

`default_nettype wire
